/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the deframer checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/afd_pkg.sv */
// ----------------------------------------------------------------------------
// afd_pkg
// Types and constants for the frame deframer with 8-bit sum checksum.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam logic [7:0] DELIM_BYTE = 8'h7E;
  localparam logic [7:0] CHECK_BASE = 8'hFF;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    logic       check_ok;
  } out_beat_t;

endpackage

/* rtl/core/afd_if.sv */
// ----------------------------------------------------------------------------
// afd_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface afd_in_if;
  import afd_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface afd_out_if;
  import afd_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/api_frame_deframer_checksum_top.sv */
// ----------------------------------------------------------------------------
// api_frame_deframer_checksum_top
// Byte-stream frame deframer: delimiter hunt, 16-bit length, payload
// pass-through, 8-bit sum checksum check at frame end.
// ----------------------------------------------------------------------------
// One byte is taken per cycle; each byte updates the phase, length and sum
// registers and, for payload and checksum bytes, loads the output register.
// Header and hunting bytes give no result. The input stalls only while the
// output register holds a result the sink has not taken.
module api_frame_deframer_checksum_top import afd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  afd_in_if.sink     in_ch,
  afd_out_if.source  out_ch
);

  phase_t      phase, phase_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  running_sum, running_sum_next;
  logic        out_valid, out_valid_next;
  out_beat_t   out_data, out_data_next;
  logic        in_fire;
  logic [7:0]  b;
  logic [15:0] len_word;
  logic [15:0] left_dec;

  assign in_ch.ready    = !out_valid || out_ch.ready;
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign b              = in_ch.payload.rx_byte;
  assign len_word       = {length_high, b};
  assign left_dec       = bytes_left - 16'd1;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_data;

  always_comb begin
    phase_next       = phase;
    length_high_next = length_high;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    out_valid_next   = out_valid && !out_ch.ready;
    out_data_next    = out_data;
    if (in_fire) begin
      unique case (phase)
        PH_LEN_HI: begin
          length_high_next = b;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          bytes_left_next = len_word;
          phase_next      = (len_word == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_sum_next = running_sum + b;
          bytes_left_next  = left_dec;
          if (left_dec == 16'd0) begin
            phase_next = PH_CHECK;
          end
          out_valid_next = 1'b1;
          out_data_next  = '{data_byte: b, frame_end: 1'b0, check_ok: 1'b0};
        end
        PH_CHECK: begin
          out_valid_next   = 1'b1;
          out_data_next    = '{data_byte: b, frame_end: 1'b1,
                               check_ok: (b == (CHECK_BASE - running_sum))};
          phase_next       = PH_HUNT;
          running_sum_next = 8'd0;
          bytes_left_next  = 16'd0;
        end
        default: begin
          if (b == DELIM_BYTE) begin
            phase_next       = PH_LEN_HI;
            running_sum_next = 8'd0;
            bytes_left_next  = 16'd0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      length_high <= 8'd0;
      bytes_left  <= 16'd0;
      running_sum <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      length_high <= length_high_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
      out_valid   <= out_valid_next;
    end
    out_data <= out_data_next;
  end

endmodule

/* rtl/core/afd_checker.sv */
// ----------------------------------------------------------------------------
// afd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_frame_end,
  input logic       out_check_ok
);

  `ASSERT_IMPLY(a_ok_only_at_end, clk, rst, out_valid && out_check_ok, out_frame_end)
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data_byte) && $stable(out_frame_end))
  `ASSERT_NEXT(a_idle_drains, clk, rst, !in_valid && (!out_valid || out_ready), !out_valid)

endmodule

bind api_frame_deframer_checksum_top afd_checker u_afd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_data_byte (out_ch.payload.data_byte),
  .out_frame_end (out_ch.payload.frame_end),
  .out_check_ok  (out_ch.payload.check_ok)
);
